// ===== src/im2c_pkg.sv =====
// ----------------------------------------------------------------------------
// im2c_pkg
// Shared widths, reset values, register indexes, state encoding and the
// command and status bundles of the im2col address generator.
// ----------------------------------------------------------------------------
package im2c_pkg;

    // Widths of the configuration fields and of the result index.
    localparam int CC_W       = 11;
    localparam int DIM_W      = 13;
    localparam int KS_W       = 4;
    localparam int IDX_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Register values after reset.
    localparam logic [CC_W-1:0]  RST_CHANNELS = 11'd3;
    localparam logic [DIM_W-1:0] RST_HEIGHT   = 13'd1080;
    localparam logic [DIM_W-1:0] RST_WIDTH    = 13'd1920;
    localparam logic [KS_W-1:0]  RST_KERNEL   = 4'd3;
    localparam logic [KS_W-1:0]  RST_STRIDE   = 4'd1;
    localparam logic [KS_W-1:0]  RST_PAD      = 4'd0;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNELS = 3'd0,
        CFG_HEIGHT   = 3'd1,
        CFG_WIDTH    = 3'd2,
        CFG_KERNEL   = 3'd3,
        CFG_STRIDE   = 3'd4,
        CFG_PAD      = 3'd5
    } t_cfg_idx;

    // Controller states.
    typedef enum logic [3:0] {
        S_HSTART,
        S_HWAIT,
        S_WSTART,
        S_WWAIT,
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_PUT
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic in_ready;
        logic load;
        logic div_start;
        logic div_sel_w;
        logic cap_h;
        logic cap_w;
        logic put;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic cfg_hit;
        logic div_done;
        logic out_free;
    } t_stat;

endpackage

// ===== src/im2c_ifs.sv =====
// ----------------------------------------------------------------------------
// im2c_item_if / im2c_res_if
// Valid/ready channels for the step requests and for the address results.
// ----------------------------------------------------------------------------
interface im2c_item_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface im2c_res_if import im2c_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] source_index;
    logic             zero_fill;
    logic             last;
    logic             valid_res;

    modport source (output valid, output source_index, output zero_fill,
                    output last, output valid_res, input ready);
    modport sink   (input valid, input source_index, input zero_fill,
                    input last, input valid_res, output ready);
endinterface

// ===== src/im2c_div.sv =====
// ----------------------------------------------------------------------------
// im2c_div
// Restoring shift-subtract divider by a 4-bit divisor, one quotient bit per
// cycle. Used to derive the output height and width.
// ----------------------------------------------------------------------------
module im2c_div import im2c_pkg::*; #(
    parameter int NUM_W = 13
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_dividend,
    input  logic [KS_W-1:0]  i_divisor,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [NUM_W-1:0] r_q;
    logic [KS_W-1:0]  r_rem;
    logic [KS_W-1:0]  r_div;

    logic [KS_W:0]    trial;
    logic             fits;

    // One trial subtraction of the partial remainder.
    always_comb begin
        trial = {r_rem, r_q[NUM_W-1]};
        fits  = trial >= {1'b0, r_div};
    end

    // Iteration counter and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CNT_W'(NUM_W);
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CNT_W'(1));
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    // Quotient and remainder shift registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_q   <= {r_q[NUM_W-2:0], fits};
            r_rem <= fits ? KS_W'(trial - {1'b0, r_div}) : KS_W'(trial);
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

// ===== src/im2c_dp.sv =====
// ----------------------------------------------------------------------------
// im2c_dp
// Datapath: configuration registers, walk counters, output dimensions,
// three-stage index arithmetic and the result register.
// ----------------------------------------------------------------------------
module im2c_dp import im2c_pkg::*; #(
    parameter int MAX_DIM      = 4096,
    parameter int MAX_CHANNELS = 1024,
    parameter int MAX_KERNEL   = 15
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_restart,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic                  i_res_ready,
    output logic                  o_res_valid,
    output logic [IDX_W-1:0]      o_source_index,
    output logic                  o_zero_fill,
    output logic                  o_last,
    output logic                  o_valid_res
);

    // Limits clipped to what the register fields can hold.
    localparam int C_MAX  = (MAX_CHANNELS < 2047) ? MAX_CHANNELS : 2047;
    localparam int K_MAX  = (MAX_KERNEL < 15) ? MAX_KERNEL : 15;
    localparam int D_MAX  = (MAX_DIM < 8191) ? MAX_DIM : 8191;
    localparam int CH_W   = (C_MAX > 1) ? $clog2(C_MAX) : 1;
    localparam int KW     = (K_MAX > 1) ? $clog2(K_MAX) : 1;
    localparam int OD_MAX = D_MAX + 30;
    localparam int OD_W   = $clog2(OD_MAX + 1);
    localparam int RC_W   = OD_W + 4;
    localparam int CR_W   = CH_W + DIM_W;

    // Configuration registers.
    logic [CC_W-1:0]  r_cfg_c;
    logic [DIM_W-1:0] r_cfg_h;
    logic [DIM_W-1:0] r_cfg_w;
    logic [KS_W-1:0]  r_cfg_k;
    logic [KS_W-1:0]  r_cfg_s;
    logic [KS_W-1:0]  r_cfg_p;

    logic cfg_hit;
    assign cfg_hit = i_cfg_we && (i_cfg_idx <= CFG_PAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_c <= RST_CHANNELS;
            r_cfg_h <= RST_HEIGHT;
            r_cfg_w <= RST_WIDTH;
            r_cfg_k <= RST_KERNEL;
            r_cfg_s <= RST_STRIDE;
            r_cfg_p <= RST_PAD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CHANNELS: r_cfg_c <= i_cfg_data[CC_W-1:0];
                CFG_HEIGHT:   r_cfg_h <= i_cfg_data[DIM_W-1:0];
                CFG_WIDTH:    r_cfg_w <= i_cfg_data[DIM_W-1:0];
                CFG_KERNEL:   r_cfg_k <= i_cfg_data[KS_W-1:0];
                CFG_STRIDE:   r_cfg_s <= i_cfg_data[KS_W-1:0];
                CFG_PAD:      r_cfg_p <= i_cfg_data[KS_W-1:0];
                default:      ;
            endcase
        end
    end

    // Effective geometry after saturation and stride fix-up.
    logic [CC_W-1:0]  eff_c;
    logic [DIM_W-1:0] eff_h;
    logic [DIM_W-1:0] eff_w;
    logic [KS_W-1:0]  eff_k;
    logic [KS_W-1:0]  eff_s;

    always_comb begin
        eff_c = (32'(r_cfg_c) > 32'(C_MAX)) ? CC_W'(C_MAX) : r_cfg_c;
        eff_h = (32'(r_cfg_h) > 32'(D_MAX)) ? DIM_W'(D_MAX) : r_cfg_h;
        eff_w = (32'(r_cfg_w) > 32'(D_MAX)) ? DIM_W'(D_MAX) : r_cfg_w;
        eff_k = (32'(r_cfg_k) > 32'(K_MAX)) ? KS_W'(K_MAX) : r_cfg_k;
        eff_s = (r_cfg_s == '0) ? KS_W'(1) : r_cfg_s;
    end

    // Output dimension derivation through the shared divider.
    logic [DIM_W-1:0] div_dim;
    logic [OD_W:0]    span;
    logic             dim_empty;
    logic [OD_W-1:0]  div_num;
    logic             div_done;
    logic [OD_W-1:0]  div_quot;
    logic [OD_W-1:0]  new_dim;
    logic [OD_W-1:0]  r_oh;
    logic [OD_W-1:0]  r_ow;

    always_comb begin
        div_dim   = i_cmd.div_sel_w ? eff_w : eff_h;
        span      = (OD_W+1)'(div_dim) + (OD_W+1)'({r_cfg_p, 1'b0});
        dim_empty = (eff_k == '0) || (span < (OD_W+1)'(eff_k));
        div_num   = OD_W'(span - (OD_W+1)'(eff_k));
        new_dim   = dim_empty ? '0 : div_quot + OD_W'(1);
    end

    im2c_div #(
        .NUM_W (OD_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_num),
        .i_divisor  (eff_s),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_h) begin
            r_oh <= new_dim;
        end
        if (i_cmd.cap_w) begin
            r_ow <= new_dim;
        end
    end

    // Walk counters, with restart applied before the current element.
    logic [KW-1:0]   r_kc, r_kr;
    logic [CH_W-1:0] r_ch;
    logic [OD_W-1:0] r_or, r_oc;

    logic [KW-1:0]   pos_kc, pos_kr, n_kc, n_kr;
    logic [CH_W-1:0] pos_ch, n_ch;
    logic [OD_W-1:0] pos_or, pos_oc, n_or, n_oc;
    logic            at_kc, at_kr, at_ch, at_or, at_oc;
    logic            geo_ok;

    always_comb begin
        pos_kc = i_restart ? '0 : r_kc;
        pos_kr = i_restart ? '0 : r_kr;
        pos_ch = i_restart ? '0 : r_ch;
        pos_or = i_restart ? '0 : r_or;
        pos_oc = i_restart ? '0 : r_oc;

        at_oc = ({1'b0, pos_oc} + (OD_W+1)'(1)) >= {1'b0, r_ow};
        at_or = ({1'b0, pos_or} + (OD_W+1)'(1)) >= {1'b0, r_oh};
        at_kc = ((KS_W+1)'(pos_kc) + (KS_W+1)'(1)) >= (KS_W+1)'(eff_k);
        at_kr = ((KS_W+1)'(pos_kr) + (KS_W+1)'(1)) >= (KS_W+1)'(eff_k);
        at_ch = ((CC_W+1)'(pos_ch) + (CC_W+1)'(1)) >= (CC_W+1)'(eff_c);

        geo_ok = (eff_c != '0) && (eff_k != '0) && (r_oh != '0) && (r_ow != '0);

        // Output column is the fastest digit, channel the slowest.
        n_kc = pos_kc;
        n_kr = pos_kr;
        n_ch = pos_ch;
        n_or = pos_or;
        n_oc = pos_oc;
        if (geo_ok) begin
            if (!at_oc) begin
                n_oc = pos_oc + OD_W'(1);
            end else begin
                n_oc = '0;
                if (!at_or) begin
                    n_or = pos_or + OD_W'(1);
                end else begin
                    n_or = '0;
                    if (!at_kc) begin
                        n_kc = pos_kc + KW'(1);
                    end else begin
                        n_kc = '0;
                        if (!at_kr) begin
                            n_kr = pos_kr + KW'(1);
                        end else begin
                            n_kr = '0;
                            n_ch = at_ch ? '0 : pos_ch + CH_W'(1);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            r_kc <= '0;
            r_kr <= '0;
            r_ch <= '0;
            r_or <= '0;
            r_oc <= '0;
        end else if (i_cmd.load) begin
            r_kc <= n_kc;
            r_kr <= n_kr;
            r_ch <= n_ch;
            r_or <= n_or;
            r_oc <= n_oc;
        end
    end

    // Snapshot of the element being computed.
    logic [KW-1:0]   r_s_kc, r_s_kr;
    logic [CH_W-1:0] r_s_ch;
    logic [OD_W-1:0] r_s_or, r_s_oc;
    logic            r_s_ok;
    logic            r_s_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_s_kc   <= pos_kc;
            r_s_kr   <= pos_kr;
            r_s_ch   <= pos_ch;
            r_s_or   <= pos_or;
            r_s_oc   <= pos_oc;
            r_s_ok   <= geo_ok;
            r_s_last <= at_oc && at_or && at_kc && at_kr && at_ch;
        end
    end

    // Stage 1: padded row and column of the element.
    logic [RC_W-1:0] r_row, r_col;

    always_ff @(posedge i_clk) begin
        r_row <= RC_W'(r_s_or) * RC_W'(eff_s) + RC_W'(r_s_kr);
        r_col <= RC_W'(r_s_oc) * RC_W'(eff_s) + RC_W'(r_s_kc);
    end

    // Stage 2: border test and channel-row base.
    logic [RC_W-1:0] pad_w, row_p, col_p;
    logic            zf_now;
    logic            r_zf;
    logic [CR_W-1:0] r_chrow;
    logic [DIM_W-1:0] r_colp;

    always_comb begin
        pad_w  = RC_W'(r_cfg_p);
        row_p  = r_row - pad_w;
        col_p  = r_col - pad_w;
        zf_now = (r_row < pad_w) || (r_col < pad_w) ||
                 (row_p >= RC_W'(eff_h)) || (col_p >= RC_W'(eff_w));
    end

    always_ff @(posedge i_clk) begin
        r_zf    <= zf_now;
        r_chrow <= CR_W'(r_s_ch) * CR_W'(eff_h) + CR_W'(DIM_W'(row_p));
        r_colp  <= DIM_W'(col_p);
    end

    // Stage 3: full pixel index, low bits kept.
    logic [IDX_W-1:0] r_idx;

    always_ff @(posedge i_clk) begin
        r_idx <= r_zf ? '0 : IDX_W'(r_chrow) * IDX_W'(eff_w) + IDX_W'(r_colp);
    end

    // Result register.
    logic             r_out_valid;
    logic [IDX_W-1:0] r_out_idx;
    logic             r_out_zf;
    logic             r_out_last;
    logic             r_out_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.put) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.put) begin
            r_out_idx  <= r_s_ok ? r_idx : '0;
            r_out_zf   <= r_s_ok && r_zf;
            r_out_last <= r_s_ok && r_s_last;
            r_out_ok   <= r_s_ok;
        end
    end

    assign o_res_valid    = r_out_valid;
    assign o_source_index = r_out_idx;
    assign o_zero_fill    = r_out_zf;
    assign o_last         = r_out_last;
    assign o_valid_res    = r_out_ok;

    assign o_stat.cfg_hit  = cfg_hit;
    assign o_stat.div_done = div_done;
    assign o_stat.out_free = !r_out_valid || i_res_ready;

endmodule

// ===== src/im2c_ctrl.sv =====
// ----------------------------------------------------------------------------
// im2c_ctrl
// Controller: sequences dimension derivation after reset and configuration
// writes, then steps each accepted beat through the datapath stages.
// ----------------------------------------------------------------------------
module im2c_ctrl import im2c_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HSTART;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state. A configuration write always restarts the derivation.
    always_comb begin
        n_state = r_state;
        if (i_stat.cfg_hit) begin
            n_state = S_HSTART;
        end else begin
            unique case (r_state)
                S_HSTART: n_state = S_HWAIT;
                S_HWAIT:  if (i_stat.div_done) n_state = S_WSTART;
                S_WSTART: n_state = S_WWAIT;
                S_WWAIT:  if (i_stat.div_done) n_state = S_IDLE;
                S_IDLE:   if (i_in_valid) n_state = S_MUL1;
                S_MUL1:   n_state = S_MUL2;
                S_MUL2:   n_state = S_MUL3;
                S_MUL3:   n_state = S_PUT;
                S_PUT:    if (i_stat.out_free) n_state = S_IDLE;
                default:  n_state = S_HSTART;
            endcase
        end
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_HSTART: o_cmd.div_start = 1'b1;
            S_HWAIT:  o_cmd.cap_h = i_stat.div_done;
            S_WSTART: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel_w = 1'b1;
            end
            S_WWAIT: begin
                o_cmd.div_sel_w = 1'b1;
                o_cmd.cap_w     = i_stat.div_done;
            end
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.load     = i_in_valid;
            end
            S_PUT:    o_cmd.put = i_stat.out_free;
            default:  o_cmd = '0;
        endcase
    end

endmodule

// ===== src/im2col_address_generator_top.sv =====
// ----------------------------------------------------------------------------
// im2col_address_generator_top
// Walks the im2col column matrix of a channel-major image and emits one
// source pixel index with zero-fill and last flags per request beat.
//
//  Channel   Dir  Handshake      Payload
//  i_item    in   valid/ready    restart
//  o_res     out  valid/ready    source_index, zero_fill, last, valid_res
//  i_cfg_*   in   write enable   i_cfg_idx, i_cfg_data
//
// The walk position of a beat is captured at acceptance, three stages form
// the row/column, the channel-row base and the index, and the PUT state
// loads the result register, after which i_item.ready returns.
// The result register holds a finished beat while the next one is taken; a
// stalled o_res holds the PUT state until the register frees up.
// After reset and after each configuration write the output height and width
// are derived by one shared bit-serial divider, with i_item.ready low.
// ----------------------------------------------------------------------------
module im2col_address_generator_top import im2c_pkg::*; #(
    parameter int MAX_DIM      = 4096,
    parameter int MAX_CHANNELS = 1024,
    parameter int MAX_KERNEL   = 15
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    im2c_item_if.sink             i_item,
    im2c_res_if.source            o_res
);

    t_cmd  cmd;
    t_stat stat;

    // Sequencing.
    im2c_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Arithmetic and storage.
    im2c_dp #(
        .MAX_DIM      (MAX_DIM),
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_KERNEL   (MAX_KERNEL)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_restart      (i_item.restart),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_res_ready    (o_res.ready),
        .o_res_valid    (o_res.valid),
        .o_source_index (o_res.source_index),
        .o_zero_fill    (o_res.zero_fill),
        .o_last         (o_res.last),
        .o_valid_res    (o_res.valid_res)
    );

    assign i_item.ready = cmd.in_ready;

endmodule

// ===== src/im2c_checker.sv =====
// ----------------------------------------------------------------------------
// im2c_checker
// Port-level checks of the im2col address generator, bound to the top level.
// ----------------------------------------------------------------------------
module im2c_checker import im2c_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_cfg_we,
    input logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input logic                  i_item_valid,
    input logic                  i_item_ready,
    input logic                  i_res_valid,
    input logic                  i_res_ready,
    input logic [IDX_W-1:0]      i_source_index,
    input logic                  i_zero_fill,
    input logic                  i_last,
    input logic                  i_valid_res
);

    // A stalled result beat keeps its index.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_source_index))
        else $error("result beat changed while stalled");

    // An empty geometry reports nothing but the invalid flag.
    a_invalid_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_valid_res |-> (i_source_index == '0) && !i_zero_fill && !i_last)
        else $error("invalid result carries data");

    // Zero-filled positions read no pixel.
    a_zero_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_zero_fill |-> i_source_index == '0)
        else $error("zero-filled result has a nonzero index");

    // One beat is in flight at a time.
    a_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item_valid && i_item_ready |=> !i_item_ready)
        else $error("request taken while a beat is in flight");

    // A register write blocks requests while dimensions are rederived.
    a_cfg_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && (i_cfg_idx <= CFG_PAD) |=> !i_item_ready)
        else $error("request taken during dimension derivation");

endmodule

bind im2col_address_generator_top im2c_checker u_im2c_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_cfg_we       (i_cfg_we),
    .i_cfg_idx      (i_cfg_idx),
    .i_item_valid   (i_item.valid),
    .i_item_ready   (i_item.ready),
    .i_res_valid    (o_res.valid),
    .i_res_ready    (o_res.ready),
    .i_source_index (o_res.source_index),
    .i_zero_fill    (o_res.zero_fill),
    .i_last         (o_res.last),
    .i_valid_res    (o_res.valid_res)
);
